// ----- hw/rtl/sefr_pkg.sv -----
// ----------------------------------------------------------------------------
// sefr_pkg
// Shared types and constants for the STX/ETX frame receiver.
// ----------------------------------------------------------------------------
package sefr_pkg;

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 6;
  localparam int TIMER_W = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Default frame store depth
  localparam int FRAME_DEPTH_DEF = 64;

  // Register indexes (paddr word index)
  localparam logic [1:0] REG_START   = 2'd0;
  localparam logic [1:0] REG_END     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // Reset values of the registers
  localparam logic [BYTE_W-1:0]  START_RST   = 8'h02;
  localparam logic [BYTE_W-1:0]  END_RST     = 8'h03;
  localparam logic [TIMER_W-1:0] TIMEOUT_RST = 16'd20;

  // Input item opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  start_code;
    logic [BYTE_W-1:0]  end_code;
    logic [TIMER_W-1:0] timeout_ticks;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic clear;     // drop frame: zero count, checksum and timer
    logic store;     // write byte, bump count, fold checksum
    logic tick_inc;  // count one idle tick
    logic rd_start;  // readout index to zero
    logic rd_en;     // issue store read
    logic rd_next;   // advance readout index
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic is_start;
    logic is_end;
    logic frame_ok;
    logic full;
    logic timeout_hit;
    logic last_rd;
  } ctl_sts_t;

endpackage

// ----- hw/rtl/sefr_ram.sv -----
// ----------------------------------------------------------------------------
// sefr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sefr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/sefr_datapath.sv -----
// ----------------------------------------------------------------------------
// sefr_datapath
// Frame store, byte count, running checksum, idle timer and readout index.
// ----------------------------------------------------------------------------
module sefr_datapath #(
  parameter int FRAME_DEPTH = sefr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sefr_pkg::cfg_t      cfg,
  input  sefr_pkg::in_item_t  in_data,
  input  sefr_pkg::ctl_cmd_t  cmd,
  output sefr_pkg::ctl_sts_t  sts,
  output sefr_pkg::out_item_t out_data
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);

  logic [CW-1:0]               count_r, count_nxt;
  logic [sefr_pkg::BYTE_W-1:0] xor_r, xor_nxt;
  logic [sefr_pkg::TIMER_W-1:0] timer_r, timer_nxt;
  logic [AW-1:0]               rd_idx_r, rd_idx_nxt;
  logic [sefr_pkg::BYTE_W-1:0] rd_byte;

  // Frame store
  sefr_ram #(
    .WIDTH (sefr_pkg::BYTE_W),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (count_r[AW-1:0]),
    .wdata (in_data.rx_byte),
    .re    (cmd.rd_en),
    .raddr (rd_idx_r),
    .rdata (rd_byte)
  );

  // Next-state of the frame bookkeeping
  always_comb begin
    count_nxt  = count_r;
    xor_nxt    = xor_r;
    timer_nxt  = timer_r;
    rd_idx_nxt = rd_idx_r;
    if (cmd.clear) begin
      count_nxt = '0;
      xor_nxt   = '0;
      timer_nxt = '0;
    end else if (cmd.store) begin
      count_nxt = count_r + CW'(1);
      xor_nxt   = xor_r ^ in_data.rx_byte;
      timer_nxt = '0;
    end else if (cmd.tick_inc) begin
      timer_nxt = timer_r + 16'd1;
    end
    if (cmd.rd_start) begin
      rd_idx_nxt = '0;
    end else if (cmd.rd_next) begin
      rd_idx_nxt = rd_idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      xor_r   <= '0;
      timer_r <= '0;
    end else begin
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
      timer_r <= timer_nxt;
    end
  end

  // Readout index is payload-like, only meaningful during readout
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
  end

  // Status toward the controller
  always_comb begin
    sts.is_tick     = (in_data.opcode == sefr_pkg::OP_TICK);
    sts.is_start    = (in_data.rx_byte == cfg.start_code);
    sts.is_end      = (in_data.rx_byte == cfg.end_code);
    sts.frame_ok    = (count_r >= CW'(2)) && (xor_r == '0);
    sts.full        = (count_r == CW'(FRAME_DEPTH));
    // tick would push the timer past the limit
    sts.timeout_hit = (timer_r >= cfg.timeout_ticks);
    sts.last_rd     = ((CW'(rd_idx_r) + CW'(2)) == count_r);
  end

  // Result item straight from the registered store read
  assign out_data.byte_index    = sefr_pkg::IDX_W'(rd_idx_r);
  assign out_data.payload_byte  = rd_byte;
  assign out_data.last_of_frame = sts.last_rd;

endmodule

// ----- hw/rtl/sefr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sefr_ctrl
// Receiver state machine: hunts for start, collects, checks, reads out.
// ----------------------------------------------------------------------------
module sefr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sefr_pkg::ctl_sts_t sts,
  output sefr_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_RD,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  // Input taken only while hunting or collecting
  assign in_stall  = !((state_r == ST_IDLE) || (state_r == ST_FRAME));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && !sts.is_tick && sts.is_start) begin
          cmd.clear = 1'b1;
          state_nxt = ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (in_acc) begin
          if (sts.is_tick) begin
            if (sts.timeout_hit) begin
              cmd.clear = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              cmd.tick_inc = 1'b1;
            end
          end else if (sts.is_end) begin
            if (sts.frame_ok) begin
              cmd.rd_start = 1'b1;
              state_nxt    = ST_RD;
            end else begin
              cmd.clear = 1'b1;
              state_nxt = ST_IDLE;
            end
          end else if (sts.full) begin
            // overflow drops the frame
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      ST_RD: begin
        cmd.rd_en     = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (sts.last_rd) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = ST_RD;
          end
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/stx_etx_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver
// STX/ETX framed serial receiver with XOR checksum and tick-based timeout.
// ----------------------------------------------------------------------------
//  channel | ports                                  | carries
//  --------+----------------------------------------+---------------------------
//  input   | in_valid, in_stall, in_data            | opcode, rx_byte
//  result  | out_valid, out_stall, out_data         | byte_index, payload_byte,
//          |                                        | last_of_frame
//  config  | psel, penable, pwrite, paddr, pwdata,  | start_code, end_code,
//          | prdata, pready                         | timeout_ticks
//
// A byte or tick item is taken without stall while hunting or collecting.
// An end byte closing a good frame of n stored bytes holds in_stall high
// while its n-1 payload bytes are read out, and for any out_stall: each needs
// one registered store read, then a turn on the output register. Reset (rst_n,
// sync) returns to idle and loads register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stx_etx_frame_receiver #(
  parameter int FRAME_DEPTH = sefr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input items
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sefr_pkg::in_item_t                in_data,
  // result items
  output logic                              out_valid,
  input  logic                              out_stall,
  output sefr_pkg::out_item_t               out_data,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sefr_pkg::ADDR_W-1:0]       paddr,
  input  logic [sefr_pkg::DATA_W-1:0]       pwdata,
  output logic [sefr_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  sefr_pkg::cfg_t     cfg_r;
  sefr_pkg::ctl_cmd_t cmd;
  sefr_pkg::ctl_sts_t sts;
  logic               wr_en;
  logic [1:0]         reg_idx;

  // Register write decode
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code    <= sefr_pkg::START_RST;
      cfg_r.end_code      <= sefr_pkg::END_RST;
      cfg_r.timeout_ticks <= sefr_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        sefr_pkg::REG_START:   cfg_r.start_code    <= pwdata[sefr_pkg::BYTE_W-1:0];
        sefr_pkg::REG_END:     cfg_r.end_code      <= pwdata[sefr_pkg::BYTE_W-1:0];
        sefr_pkg::REG_TIMEOUT: cfg_r.timeout_ticks <= pwdata[sefr_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read mux
  always_comb begin
    case (reg_idx)
      sefr_pkg::REG_START:   prdata = sefr_pkg::DATA_W'(cfg_r.start_code);
      sefr_pkg::REG_END:     prdata = sefr_pkg::DATA_W'(cfg_r.end_code);
      sefr_pkg::REG_TIMEOUT: prdata = sefr_pkg::DATA_W'(cfg_r.timeout_ticks);
      default:               prdata = '0;
    endcase
  end

  sefr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sefr_datapath #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
